/* rtl/mhpq_pkg.sv */
// Shared constants, types and codes for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

	localparam int CAPACITY    = 256;
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 16;
	localparam int ADDR_BITS   = $clog2(CAPACITY);
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	// child indices and compares against the count need headroom for 2*pos+2
	localparam int WIDE_BITS   = ADDR_BITS + 2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_EX_RD,
		S_EX_LOAD,
		S_DN_CHK,
		S_DN_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic start;     // capture the request and set the default result
		logic ins_begin; // hole at the tail, count up
		logic up_read;   // read the parent of the hole
		logic up_move;   // move the parent down into the hole
		logic ex_read;   // read root and tail
		logic ex_load;   // take the root as result, tail as moving entry
		logic dn_read;   // read both children of the hole
		logic dn_move;   // move the smaller child up into the hole
		logic place;     // write the moving entry into the hole
		logic load_out;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_root;
		logic up_swap;
		logic lc_out;
		logic dn_swap;
		logic out_busy;
	} stat_t;

endpackage

/* rtl/mhpq_ctrl.sv */
// Controller state machine sequencing insert and extract operations.
`timescale 1ns / 1ps

module mhpq_ctrl import mhpq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	input  logic   operation,
	output logic   req_stall,
	output cmd_t   cmd,
	input  stat_t  stat
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					if (operation == OP_INSERT) begin
						if (stat.full) begin
							state_d = S_RESP;
						end else begin
							cmd.ins_begin = 1'b1;
							state_d       = S_UP_CHK;
						end
					end else begin
						state_d = stat.empty ? S_RESP : S_EX_RD;
					end
				end
			end
			S_UP_CHK: begin
				if (stat.pos_root) begin
					cmd.place = 1'b1;
					state_d   = S_RESP;
				end else begin
					cmd.up_read = 1'b1;
					state_d     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_swap) begin
					cmd.up_move = 1'b1;
					state_d     = S_UP_CHK;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_RESP;
				end
			end
			S_EX_RD: begin
				cmd.ex_read = 1'b1;
				state_d     = S_EX_LOAD;
			end
			S_EX_LOAD: begin
				cmd.ex_load = 1'b1;
				state_d     = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (stat.lc_out) begin
					cmd.place = 1'b1;
					state_d   = S_RESP;
				end else begin
					cmd.dn_read = 1'b1;
					state_d     = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_swap) begin
					cmd.dn_move = 1'b1;
					state_d     = S_DN_CHK;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_RESP;
				end
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/mhpq_datapath.sv */
// Heap storage, moving-entry registers, comparators and output register.
`timescale 1ns / 1ps

module mhpq_datapath import mhpq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   operation,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [HANDLE_BITS-1:0] handle,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [KEY_BITS-1:0]    out_key,
	output logic [HANDLE_BITS-1:0] out_handle,
	output logic [1:0]             status,
	output logic [COUNT_BITS-1:0]  count
);

	entry_t mem [CAPACITY];

	logic [COUNT_BITS-1:0]  count_q;
	logic                   out_valid_q;
	logic [ADDR_BITS-1:0]   pos_q;
	entry_t                 ent_q;
	entry_t                 rd_a_q;
	entry_t                 rd_b_q;
	logic [KEY_BITS-1:0]    res_key_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic [1:0]             res_status_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [1:0]             out_status_q;
	logic [COUNT_BITS-1:0]  out_count_q;

	logic [WIDE_BITS-1:0]   lc;
	logic [WIDE_BITS-1:0]   rc;
	logic [WIDE_BITS-1:0]   count_w;
	logic [ADDR_BITS-1:0]   parent;
	logic [ADDR_BITS-1:0]   tail;
	logic [ADDR_BITS-1:0]   rd_addr_a;
	logic [ADDR_BITS-1:0]   rd_addr_b;
	logic                   rc_valid;
	logic                   sel_left;
	logic                   sel_right;
	logic [KEY_BITS-1:0]    best_key;
	logic                   we;
	logic [ADDR_BITS-1:0]   wr_addr;
	entry_t                 wr_data;

	assign lc       = {1'b0, pos_q, 1'b1};
	assign rc       = lc + WIDE_BITS'(1);
	assign count_w  = WIDE_BITS'(count_q);
	assign parent   = (pos_q - ADDR_BITS'(1)) >> 1;
	assign tail     = ADDR_BITS'(count_q - COUNT_BITS'(1));
	assign rc_valid = rc < count_w;

	// strict compares: ties keep the entry where it is, and prefer the left child
	assign sel_left  = rd_a_q.key < ent_q.key;
	assign best_key  = sel_left ? rd_a_q.key : ent_q.key;
	assign sel_right = rc_valid && (rd_b_q.key < best_key);

	assign stat.full     = count_q == COUNT_BITS'(CAPACITY);
	assign stat.empty    = count_q == '0;
	assign stat.pos_root = pos_q == '0;
	assign stat.up_swap  = rd_a_q.key > ent_q.key;
	assign stat.lc_out   = lc >= count_w;
	assign stat.dn_swap  = sel_left || sel_right;
	assign stat.out_busy = out_valid_q && rsp_stall;

	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		if (cmd.ex_read) begin
			rd_addr_a = '0;
			rd_addr_b = tail;
		end else if (cmd.up_read) begin
			rd_addr_a = parent;
		end else if (cmd.dn_read) begin
			rd_addr_a = lc[ADDR_BITS-1:0];
			rd_addr_b = rc[ADDR_BITS-1:0];
		end
	end

	always_comb begin
		we      = cmd.place || cmd.up_move || cmd.dn_move;
		wr_addr = pos_q;
		wr_data = ent_q;
		if (cmd.up_move) begin
			wr_data = rd_a_q;
		end else if (cmd.dn_move) begin
			wr_data = sel_right ? rd_b_q : rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_begin) begin
				count_q <= count_q + COUNT_BITS'(1);
			end else if (cmd.ex_load) begin
				count_q <= count_q - COUNT_BITS'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ent_q.key    <= key;
			ent_q.handle <= handle;
			res_key_q    <= '0;
			res_handle_q <= '0;
			if (operation == OP_INSERT && stat.full) begin
				res_status_q <= ST_FULL;
			end else if (operation == OP_EXTRACT && stat.empty) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (cmd.ins_begin) begin
			pos_q <= count_q[ADDR_BITS-1:0];
		end else if (cmd.up_move) begin
			pos_q <= parent;
		end else if (cmd.ex_load) begin
			pos_q <= '0;
		end else if (cmd.dn_move) begin
			pos_q <= sel_right ? rc[ADDR_BITS-1:0] : lc[ADDR_BITS-1:0];
		end
		if (cmd.ex_load) begin
			res_key_q    <= rd_a_q.key;
			res_handle_q <= rd_a_q.handle;
			ent_q        <= rd_b_q;
		end
		if (cmd.load_out) begin
			out_key_q    <= res_key_q;
			out_handle_q <= res_handle_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign out_key    = out_key_q;
	assign out_handle = out_handle_q;
	assign status     = out_status_q;
	assign count      = out_count_q;

endmodule

/* rtl/min_heap_priority_queue.sv */
// Binary min-heap priority queue: request channel in, one response per request out.
//
// Request channel (req_valid/req_stall, operation/key/handle): operation 0 inserts
// (key, handle), operation 1 extracts the entry with the smallest key. A transfer
// takes place on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid/rsp_stall): out_key/out_handle carry the extracted
// entry (zero for inserts and errors), status is 0 ok, 1 extract from an empty
// heap, 2 insert into a full heap; count is the number of entries afterwards.
// One request is worked on at a time. An insert rises L levels (0..8) toward
// the root, stopping early when its parent is not larger; an extract sinks L
// levels (0..7), stopping at a leaf or when no child is smaller. Each level
// costs one registered memory read and one compare-and-write step; sift down
// reads both children in the same cycle, the right one through the second port.
// Errored requests go straight to the response state. The next request is taken
// the cycle after the result moves to the output register, even while that
// result is stalled.
// Reset empties the heap at once (count zero; storage is not cleared) and drops
// any pending response. While rsp_stall is high the response holds unchanged and
// a finished result waits inside until the output register frees.
`timescale 1ns / 1ps

module min_heap_priority_queue import mhpq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   operation,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [HANDLE_BITS-1:0] handle,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [KEY_BITS-1:0]    out_key,
	output logic [HANDLE_BITS-1:0] out_handle,
	output logic [1:0]             status,
	output logic [COUNT_BITS-1:0]  count
);

	cmd_t  cmd;
	stat_t stat;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (operation),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	mhpq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.key        (key),
		.handle     (handle),
		.cmd        (cmd),
		.stat       (stat),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.out_key    (out_key),
		.out_handle (out_handle),
		.status     (status),
		.count      (count)
	);

endmodule
